### rtl/spce_pkg.sv
// shared types and constants for the shortest path cost engine
`default_nettype none
package spce_pkg;

    typedef enum logic [2:0] {
        OP_ADD_NODE = 3'd0,
        OP_DEL_NODE = 3'd1,
        OP_SET_EDGE = 3'd2,
        OP_DEL_EDGE = 3'd3,
        OP_QUERY    = 3'd4
    } opcode_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DROP  = 6'b000100,
        ST_EDGE2 = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_RELAX = 6'b100000
    } state_t;

    localparam int unsigned TIME_BASE  = 120;
    localparam int unsigned TIME_SCALE = 40;

endpackage
`default_nettype wire

### rtl/spce_ram.sv
// single write port, single read port ram with registered read data
`default_nettype none
module spce_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 9
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/shortest_path_cost_engine_unit.sv
// top level: graph store and single pair dijkstra sequencer
//
//  channel   ports                                          handshake
//  command   opcode node_a node_b weight time_mode          start, busy
//  result    path_cost reachable                            done (one cycle strobe)
//
// after reset the edge ram is swept clear with busy high
// add / remove node: clears the node's row and column, one ram write per entry
// set / remove edge: one ram write per direction
// query: per settled node a check, one read per node, a drain and a pick,
//   with the one read port of the edge ram walking the adjacency row
// the receiver cannot stall: done marks a result word for one cycle only
`default_nettype none
module shortest_path_cost_engine_unit
    import spce_pkg::*;
#(
    parameter int unsigned VERTICES    = 32,
    parameter int unsigned WEIGHT_BITS = 8,
    parameter int unsigned COST_BITS   = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [4:0]  node_a,
    input  wire logic [4:0]  node_b,
    input  wire logic [7:0]  weight,
    input  wire logic        time_mode,
    output logic             done,
    output logic [19:0]      path_cost,
    output logic             reachable
);

    localparam int unsigned VW    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int unsigned AW    = $clog2(VERTICES * VERTICES);
    localparam int unsigned EW    = WEIGHT_BITS + 1;
    localparam int unsigned SW    = COST_BITS + WEIGHT_BITS + 8;
    localparam int unsigned CW    = VW + 1;
    localparam logic [8:0]    VLIM      = 9'(VERTICES);
    localparam logic [AW-1:0] CLR_LAST  = AW'(VERTICES * VERTICES - 1);
    localparam logic [CW-1:0] CNT_END   = CW'(VERTICES);
    localparam logic [VW-1:0] V_LAST    = VW'(VERTICES - 1);
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    function automatic logic [AW-1:0] edge_addr(input logic [VW-1:0] row,
                                                 input logic [VW-1:0] col);
        edge_addr = AW'(row) * AW'(VERTICES) + AW'(col);
    endfunction

    // control and payload registers
    state_t                 state_reg, state_next;
    logic [VERTICES-1:0]    present_reg, present_next;
    logic [VERTICES-1:0]    known_reg, known_next;
    logic [VERTICES-1:0]    settled_reg, settled_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   half_reg, half_next;
    logic [VW-1:0]          a_reg, a_next;
    logic [VW-1:0]          b_reg, b_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic                   eset_reg, eset_next;
    logic                   timed_reg, timed_next;
    logic [VW-1:0]          best_reg, best_next;
    logic [COST_BITS-1:0]   bcost_reg, bcost_next;
    logic                   found_reg, found_next;
    logic [VW-1:0]          cand_reg, cand_next;
    logic [COST_BITS-1:0]   ccost_reg, ccost_next;
    logic                   pend_reg, pend_next;
    logic [VW-1:0]          pv_reg, pv_next;
    logic                   done_reg, done_next;
    logic [19:0]            cost_reg, cost_next;
    logic                   reach_reg, reach_next;

    // ram ports
    logic                   e_we;
    logic [AW-1:0]          e_waddr, e_raddr;
    logic [EW-1:0]          e_wdata, e_rdata;
    logic                   d_we;
    logic [VW-1:0]          d_waddr, d_raddr;
    logic [COST_BITS-1:0]   d_wdata, d_rdata;

    // decoded command word
    logic                   a_ok, b_ok;
    logic [VW-1:0]          a_idx, b_idx;
    logic [WEIGHT_BITS-1:0] w_in;

    // relax datapath for the word read last cycle
    logic                   ep;
    logic [WEIGHT_BITS-1:0] ew;
    logic [SW-1:0]          tw, sum;
    logic [COST_BITS-1:0]   nc, newd;
    logic                   elig, upd, cand_ok;

    spce_ram #(.DEPTH(VERTICES * VERTICES), .WIDTH(EW)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    spce_ram #(.DEPTH(2 ** VW), .WIDTH(COST_BITS)) u_cost_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign a_ok  = (9'(node_a) < VLIM);
    assign b_ok  = (9'(node_b) < VLIM);
    assign a_idx = VW'(node_a);
    assign b_idx = VW'(node_b);
    assign w_in  = WEIGHT_BITS'(weight);

    // edge cost, either plain distance or travel time, then a saturating add
    assign ep   = e_rdata[WEIGHT_BITS];
    assign ew   = e_rdata[WEIGHT_BITS-1:0];
    assign tw   = timed_reg ? (SW'(TIME_BASE) + SW'(TIME_SCALE) * SW'(ew)) : SW'(ew);
    assign sum  = SW'(bcost_reg) + tw;
    assign nc   = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_BITS-1:0];
    assign elig = ep && !settled_reg[pv_reg] && present_reg[pv_reg];
    assign upd  = elig && (!known_reg[pv_reg] || (nc < d_rdata));
    assign newd = upd ? nc : d_rdata;
    assign cand_ok = present_reg[pv_reg] && !settled_reg[pv_reg]
                     && (known_reg[pv_reg] || upd);

    always_comb
    begin
        state_next   = state_reg;
        present_next = present_reg;
        known_next   = known_reg;
        settled_next = settled_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        half_next    = half_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        w_next       = w_reg;
        eset_next    = eset_reg;
        timed_next   = timed_reg;
        best_next    = best_reg;
        bcost_next   = bcost_reg;
        found_next   = found_reg;
        cand_next    = cand_reg;
        ccost_next   = ccost_reg;
        pend_next    = 1'b0;
        pv_next      = pv_reg;
        done_next    = 1'b0;
        cost_next    = cost_reg;
        reach_next   = reach_reg;

        e_we    = 1'b0;
        e_waddr = edge_addr(a_reg, b_reg);
        e_wdata = {1'b0, w_reg};
        e_raddr = edge_addr(best_reg, cnt_reg[VW-1:0]);
        d_we    = 1'b0;
        d_waddr = pv_reg;
        d_wdata = newd;
        d_raddr = cnt_reg[VW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep every edge entry to absent after reset
                e_we     = 1'b1;
                e_waddr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next     = a_idx;
                    b_next     = b_idx;
                    w_next     = w_in;
                    timed_next = time_mode;
                    cnt_next   = '0;
                    half_next  = 1'b0;
                    unique case (opcode)
                        OP_ADD_NODE:
                        begin
                            if (a_ok)
                            begin
                                present_next[a_idx] = 1'b1;
                                state_next          = ST_DROP;
                            end
                        end
                        OP_DEL_NODE:
                        begin
                            if (a_ok && present_reg[a_idx])
                            begin
                                present_next[a_idx] = 1'b0;
                                state_next          = ST_DROP;
                            end
                        end
                        OP_SET_EDGE:
                        begin
                            if (a_ok && b_ok && present_reg[a_idx] && present_reg[b_idx])
                            begin
                                e_we       = 1'b1;
                                e_waddr    = edge_addr(a_idx, b_idx);
                                e_wdata    = {1'b1, w_in};
                                eset_next  = 1'b1;
                                state_next = ST_EDGE2;
                            end
                        end
                        OP_DEL_EDGE:
                        begin
                            // edges are kept symmetric, so clearing both ways is safe
                            if (a_ok && b_ok)
                            begin
                                e_we       = 1'b1;
                                e_waddr    = edge_addr(a_idx, b_idx);
                                e_wdata    = {1'b0, w_in};
                                eset_next  = 1'b0;
                                state_next = ST_EDGE2;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (a_ok && b_ok && present_reg[a_idx] && present_reg[b_idx])
                            begin
                                known_next        = '0;
                                known_next[a_idx] = 1'b1;
                                settled_next      = '0;
                                best_next         = a_idx;
                                bcost_next        = '0;
                                state_next        = ST_CHECK;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                cost_next  = '0;
                                reach_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DROP:
            begin
                // row entry first, then column entry, for every node index
                e_we      = 1'b1;
                e_waddr   = half_reg ? edge_addr(cnt_reg[VW-1:0], a_reg)
                                     : edge_addr(a_reg, cnt_reg[VW-1:0]);
                e_wdata   = '0;
                half_next = !half_reg;
                if (half_reg)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg[VW-1:0] == V_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EDGE2:
            begin
                e_we       = 1'b1;
                e_waddr    = edge_addr(b_reg, a_reg);
                e_wdata    = {eset_reg, w_reg};
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (best_reg == b_reg)
                begin
                    done_next  = 1'b1;
                    cost_next  = 20'(bcost_reg);
                    reach_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    settled_next[best_reg] = 1'b1;
                    found_next             = 1'b0;
                    cnt_next               = '0;
                    state_next             = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                // issue reads for node cnt, relax the node read in the previous cycle
                if (cnt_reg < CNT_END)
                begin
                    pend_next = 1'b1;
                    pv_next   = cnt_reg[VW-1:0];
                    cnt_next  = cnt_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (upd)
                    begin
                        d_we               = 1'b1;
                        known_next[pv_reg] = 1'b1;
                    end
                    // running minimum picks the next node, lowest index on ties
                    if (cand_ok && (!found_reg || (newd < ccost_reg)))
                    begin
                        found_next = 1'b1;
                        cand_next  = pv_reg;
                        ccost_next = newd;
                    end
                end
                else if (cnt_reg == CNT_END)
                begin
                    if (found_reg)
                    begin
                        best_next  = cand_reg;
                        bcost_next = ccost_reg;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        cost_next  = '0;
                        reach_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            present_reg <= '0;
            known_reg   <= '0;
            settled_reg <= '0;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            half_reg    <= 1'b0;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cost_reg    <= '0;
            reach_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            known_reg   <= known_next;
            settled_reg <= settled_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            half_reg    <= half_next;
            found_reg   <= found_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            cost_reg    <= cost_next;
            reach_reg   <= reach_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        w_reg     <= w_next;
        eset_reg  <= eset_next;
        timed_reg <= timed_next;
        best_reg  <= best_next;
        bcost_reg <= bcost_next;
        cand_reg  <= cand_next;
        ccost_reg <= ccost_next;
        pv_reg    <= pv_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign path_cost = cost_reg;
    assign reachable = reach_reg;

endmodule
`default_nettype wire

### tb/sv/spce_path_checker.sv
// checker: watches command and result words, predicts query costs, compares
`timescale 1ns / 1ps
module spce_path_checker
    import spce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [4:0]  node_a,
    input  wire logic [4:0]  node_b,
    input  wire logic [7:0]  weight,
    input  wire logic        time_mode,
    input  wire logic        done,
    input  wire logic [19:0] path_cost,
    input  wire logic        reachable,
    output int               fail_count,
    output int               pending_count
);
    localparam int N = 32;
    localparam int DUE_DEPTH = 16;
    localparam logic [19:0] COST_SAT = 20'hFFFFF;

    typedef struct packed {
        logic [19:0] cost;
        logic        reach;
    } answer_t;

    logic       have_node [N];
    logic       link_on   [N][N];
    logic [7:0] link_wt   [N][N];
    answer_t    answers_due [DUE_DEPTH];
    int         due_head = 0;
    int         due_tail = 0;

    function automatic logic [19:0] add_sat(logic [19:0] x, logic [31:0] y);
        logic [32:0] s;
        s = 33'(x) + 33'(y);
        return (s > 33'(COST_SAT)) ? COST_SAT : s[19:0];
    endfunction

    function automatic answer_t shortest_cost(int src, int dst, logic timed);
        answer_t     r;
        logic [19:0] cost_so_far [N];
        logic        known [N];
        logic        done_n [N];
        int          best;
        logic [31:0] step;
        logic [19:0] nc;
        r = '0;
        if (!have_node[src] || !have_node[dst]) return r;
        for (int i = 0; i < N; i++) begin
            cost_so_far[i] = '0; known[i] = 1'b0; done_n[i] = 1'b0;
        end
        known[src] = 1'b1;
        forever begin
            best = -1;
            for (int i = 0; i < N; i++)
                if (have_node[i] && known[i] && !done_n[i])
                    if (best < 0 || cost_so_far[i] < cost_so_far[best]) best = i;
            if (best < 0) return r;
            if (best == dst) begin
                r.cost = cost_so_far[best]; r.reach = 1'b1;
                return r;
            end
            done_n[best] = 1'b1;
            for (int v = 0; v < N; v++) begin
                if (!link_on[best][v] || done_n[v] || !have_node[v]) continue;
                step = 32'(link_wt[best][v]);
                if (timed) step = 32'(TIME_BASE) + 32'(TIME_SCALE) * step;
                nc = add_sat(cost_so_far[best], step);
                if (!known[v] || nc < cost_so_far[v]) begin
                    cost_so_far[v] = nc; known[v] = 1'b1;
                end
            end
        end
    endfunction

    assign pending_count = due_tail - due_head;

    always @(posedge clk or negedge rst_n) begin
        answer_t want;
        if (!rst_n) begin
            fail_count <= 0;
            due_head = 0;
            due_tail = 0;
            for (int i = 0; i < N; i++) begin
                have_node[i] = 1'b0;
                for (int j = 0; j < N; j++) link_on[i][j] = 1'b0;
            end
        end else begin
            if (done) begin
                if (due_tail == due_head) begin
                    $display("%0t: unexpected result word cost=%0d reach=%0b",
                             $time, path_cost, reachable);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers_due[due_head % DUE_DEPTH];
                    due_head = due_head + 1;
                    if (want.cost !== path_cost || want.reach !== reachable) begin
                        $display("%0t: cost expected %0d actual %0d, reach expected %0b actual %0b",
                                 $time, want.cost, path_cost, want.reach, reachable);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                case (opcode)
                    OP_ADD_NODE: begin
                        for (int u = 0; u < N; u++) begin
                            link_on[node_a][u] = 1'b0; link_on[u][node_a] = 1'b0;
                        end
                        have_node[node_a] = 1'b1;
                    end
                    OP_DEL_NODE: if (have_node[node_a]) begin
                        for (int u = 0; u < N; u++) begin
                            link_on[node_a][u] = 1'b0; link_on[u][node_a] = 1'b0;
                        end
                        have_node[node_a] = 1'b0;
                    end
                    OP_SET_EDGE: if (have_node[node_a] && have_node[node_b]) begin
                        link_on[node_a][node_b] = 1'b1; link_on[node_b][node_a] = 1'b1;
                        link_wt[node_a][node_b] = weight; link_wt[node_b][node_a] = weight;
                    end
                    OP_DEL_EDGE: if (link_on[node_a][node_b]) begin
                        link_on[node_a][node_b] = 1'b0; link_on[node_b][node_a] = 1'b0;
                    end
                    OP_QUERY: begin
                        answers_due[due_tail % DUE_DEPTH] =
                            shortest_cost(int'(node_a), int'(node_b), time_mode);
                        due_tail = due_tail + 1;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

### tb/sv/tb_shortest_path_cost_engine_unit.sv
// testbench top: command stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module tb_shortest_path_cost_engine_unit
    import spce_pkg::*;
();

    // no cycle accepts anything during the post-reset ram sweep or a long
    // query, so this bound leaves plenty of margin
    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  opcode = '0;
    logic [4:0]  node_a = '0;
    logic [4:0]  node_b = '0;
    logic [7:0]  weight = '0;
    logic        time_mode = 1'b0;
    logic        busy, done, reachable;
    logic [19:0] path_cost;
    int          fail_count, pending_count;
    int          quiet_cycles = 0;

    always #10 clk = ~clk;

    shortest_path_cost_engine_unit dut (.*);

    spce_path_checker checker_i (.*);

    // watchdog: counts cycles with no command or result word taken
    always @(posedge clk) begin
        if ((start && !busy) || done || !rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("shortest_path_cost_engine_unit: mismatch");
            $finish;
        end
    end

    // present one command word and hold it until taken
    task automatic issue_word(logic [2:0] op, logic [4:0] a, logic [4:0] b,
                              logic [7:0] w, logic tm);
        start <= 1'b1; opcode <= op; node_a <= a; node_b <= b;
        weight <= w; time_mode <= tm;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random word weighted toward building a dense graph over a few nodes
    task automatic random_word(int span);
        int          pick;
        logic [4:0]  a, b;
        logic [7:0]  w;
        logic        tm;
        pick = $urandom_range(99);
        a = 5'($urandom_range(span - 1));
        b = 5'($urandom_range(span - 1));
        w = 8'($urandom);
        tm = 1'($urandom);
        if (pick < 15)      issue_word(OP_ADD_NODE, a, b, w, tm);
        else if (pick < 20) issue_word(OP_DEL_NODE, a, b, w, tm);
        else if (pick < 55) issue_word(OP_SET_EDGE, a, b, w, tm);
        else if (pick < 62) issue_word(OP_DEL_EDGE, a, b, w, tm);
        else if (pick < 96) issue_word(OP_QUERY, a, b, w, tm);
        else                issue_word(3'($urandom_range(5, 7)), a, b, w, tm);
    endtask

    initial begin
        int burst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty graph, extremes, self edge, long chains, unused opcodes
        issue_word(OP_QUERY, 5'd0, 5'd0, 8'd0, 1'b0);
        issue_word(OP_ADD_NODE, 5'd0, 5'd0, 8'd0, 1'b0);
        issue_word(OP_ADD_NODE, 5'd31, 5'd0, 8'd0, 1'b0);
        issue_word(OP_QUERY, 5'd0, 5'd0, 8'd0, 1'b1);
        issue_word(OP_QUERY, 5'd0, 5'd31, 8'd0, 1'b0);
        issue_word(OP_SET_EDGE, 5'd0, 5'd31, 8'd255, 1'b0);
        issue_word(OP_SET_EDGE, 5'd0, 5'd0, 8'd1, 1'b0);
        issue_word(OP_SET_EDGE, 5'd0, 5'd7, 8'd9, 1'b0);
        issue_word(OP_QUERY, 5'd31, 5'd0, 8'd0, 1'b0);
        issue_word(OP_QUERY, 5'd0, 5'd31, 8'd0, 1'b1);
        for (int i = 1; i < 31; i++) issue_word(OP_ADD_NODE, 5'(i), 5'd0, 8'd0, 1'b0);
        for (int i = 0; i < 31; i++) issue_word(OP_SET_EDGE, 5'(i), 5'(i + 1), 8'd255, 1'b0);
        issue_word(OP_DEL_EDGE, 5'd0, 5'd31, 8'd0, 1'b0);
        issue_word(OP_QUERY, 5'd0, 5'd31, 8'd0, 1'b1);
        issue_word(OP_DEL_EDGE, 5'd3, 5'd9, 8'd0, 1'b0);
        issue_word(OP_DEL_NODE, 5'd15, 5'd0, 8'd0, 1'b0);
        issue_word(OP_QUERY, 5'd0, 5'd31, 8'd0, 1'b0);
        issue_word(OP_DEL_NODE, 5'd15, 5'd0, 8'd0, 1'b0);
        issue_word(3'd5, 5'd1, 5'd2, 8'd0, 1'b0);
        issue_word(3'd7, 5'd1, 5'd2, 8'd0, 1'b0);
        issue_word(OP_ADD_NODE, 5'd31, 5'd0, 8'd0, 1'b0);
        issue_word(OP_QUERY, 5'd30, 5'd31, 8'd0, 1'b0);

        // hold off until every outstanding answer is back
        start <= 1'b0;
        while (pending_count != 0) @(posedge clk);

        // random bursts; span mostly small so queries hit connected graphs
        for (int n = 0; n < 460; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++)
                random_word(($urandom_range(3) == 0) ? 32 : 8);
            if ($urandom_range(3) != 0) idle_gap($urandom_range(1, 15));
        end
        start <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("shortest_path_cost_engine_unit: match");
        else
            $display("shortest_path_cost_engine_unit: mismatch");
        $finish;
    end
endmodule

### shortest_path_cost_engine_unit.f
rtl/spce_pkg.sv
rtl/spce_ram.sv
rtl/shortest_path_cost_engine_unit.sv
tb/sv/spce_path_checker.sv
tb/sv/tb_shortest_path_cost_engine_unit.sv
